// ----- rtl/core/kpsdq_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsdq_pkg
// Shared types and constants of the keypad scanner with debounce and key queue
// ----------------------------------------------------------------------------
package kpsdq_pkg;

    localparam int COL_W      = 4;   // column sample width
    localparam int ROW_W      = 2;   // row select width
    localparam int CODE_W     = 8;   // key code width
    localparam int DEB_W      = 8;   // debounce count width
    localparam int CTR_W      = 9;   // per-row stability counter width
    localparam int KEYMAP_W   = 64;
    localparam int ENTRY_W    = 4;   // key table entry = row*4 + column
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HIGH = 2'd2;

    localparam logic [DEB_W-1:0]    DEBOUNCE_RST    = 8'd5;
    localparam logic [KEYMAP_W-1:0] KEYMAP_LOW_RST  = 64'h4423_302A_4133_3231;
    localparam logic [KEYMAP_W-1:0] KEYMAP_HIGH_RST = 64'h4236_3534_4339_3837;

    // input actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ----- rtl/core/kpsdq_item_if.sv -----
// ----------------------------------------------------------------------------
// kpsdq_item_if
// Input channel: scan tick with column sample, or read of the oldest key
// ----------------------------------------------------------------------------
interface kpsdq_item_if;

    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [kpsdq_pkg::COL_W-1:0] column_sample;

    modport source (output valid, output action, output column_sample, input ready);
    modport sink   (input valid, input action, input column_sample, output ready);

endinterface

// ----- rtl/core/kpsdq_result_if.sv -----
// ----------------------------------------------------------------------------
// kpsdq_result_if
// Result channel: popped key, next row to drive, drop flag and queue fill
// ----------------------------------------------------------------------------
interface kpsdq_result_if #(
    parameter int CNT_W = 4
);

    logic                         valid;
    logic                         ready;
    logic                         key_valid;
    logic [kpsdq_pkg::CODE_W-1:0] key_code;
    logic [kpsdq_pkg::ROW_W-1:0]  row_select;
    logic                         key_dropped;
    logic [CNT_W-1:0]             queue_count;

    modport source (
        output valid, output key_valid, output key_code, output row_select,
        output key_dropped, output queue_count, input ready
    );
    modport sink (
        input valid, input key_valid, input key_code, input row_select,
        input key_dropped, input queue_count, output ready
    );

endinterface

// ----- rtl/core/kpsdq_fifo.sv -----
// ----------------------------------------------------------------------------
// kpsdq_fifo
// Key code queue with registered read data, cleared to zero when nothing pops
// ----------------------------------------------------------------------------
module kpsdq_fifo #(
    parameter int DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_push,
    input  logic                         i_pop,
    input  logic [kpsdq_pkg::CODE_W-1:0] i_push_data,
    output logic [kpsdq_pkg::CODE_W-1:0] o_rd_data,
    output logic [CNT_W-1:0]             o_count,
    output kpsdq_pkg::t_fifo_status      o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [kpsdq_pkg::CODE_W-1:0] mem [DEPTH];
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_tail, n_tail;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [kpsdq_pkg::CODE_W-1:0] r_rd_data;
    logic                         do_push, do_pop;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        nxt = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
        return nxt;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    assign do_push = i_step && i_push && !o_status.full;
    assign do_pop  = i_step && i_pop && !o_status.empty;

    always_comb begin
        n_head  = do_pop ? wrap_inc(r_head) : r_head;
        n_tail  = do_push ? wrap_inc(r_tail) : r_tail;
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_tail] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_rd_data <= do_pop ? mem[r_head] : '0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

// ----- rtl/core/keypad_scan_debounce_queue.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_queue
// Row-by-row keypad scanner with per-row debounce and a queue of key codes
// ----------------------------------------------------------------------------
// pipeline: input register, then result register
// throughput: one transaction per cycle while the result side is ready; the row state and queue
//   update as a transaction moves from the input register to the result register
// reset: debounce count 5, default key map, row 0, all row samples and
//   counters zero, queue empty
module keypad_scan_debounce_queue #(
    parameter int ROWS        = 4,
    parameter int COLUMNS     = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kpsdq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kpsdq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kpsdq_item_if.sink                       i_item,
    kpsdq_result_if.source                   o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RIX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [kpsdq_pkg::COL_W-1:0] COL_MASK =
        kpsdq_pkg::COL_W'((1 << COLUMNS) - 1);

    // configuration
    logic [kpsdq_pkg::DEB_W-1:0]    r_debounce;
    logic [kpsdq_pkg::KEYMAP_W-1:0] r_keymap_low;
    logic [kpsdq_pkg::KEYMAP_W-1:0] r_keymap_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= kpsdq_pkg::DEBOUNCE_RST;
            r_keymap_low  <= kpsdq_pkg::KEYMAP_LOW_RST;
            r_keymap_high <= kpsdq_pkg::KEYMAP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpsdq_pkg::CFG_DEBOUNCE:
                    r_debounce <= i_cfg_data[kpsdq_pkg::DEB_W-1:0];
                kpsdq_pkg::CFG_KEYMAP_LOW:  r_keymap_low  <= i_cfg_data;
                kpsdq_pkg::CFG_KEYMAP_HIGH: r_keymap_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                        r_in_valid, r_res_valid;
    logic                        r_action;
    logic [kpsdq_pkg::COL_W-1:0] r_sample;
    logic                        advance, step, in_fire;

    assign advance      = !r_res_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;
    assign in_fire      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= i_item.action;
            r_sample <= i_item.column_sample;
        end
    end

    // per-row debounce state
    logic [kpsdq_pkg::COL_W-1:0] r_pending [ROWS];
    logic [kpsdq_pkg::COL_W-1:0] r_stable  [ROWS];
    logic [kpsdq_pkg::CTR_W-1:0] r_counter [ROWS];
    logic [kpsdq_pkg::ROW_W-1:0] r_row, n_row;

    logic [RIX_W-1:0]              ridx;
    logic                          is_tick;
    logic [kpsdq_pkg::COL_W-1:0]   sample, cur_pending, cur_stable, hit;
    logic [kpsdq_pkg::CTR_W-1:0]   cur_cnt, limit;
    logic                          changed, counting, settle, found;
    logic [1:0]                    hit_col;
    logic [kpsdq_pkg::ENTRY_W-1:0] entry;
    logic [2*kpsdq_pkg::KEYMAP_W-1:0] keymap;
    logic [kpsdq_pkg::CODE_W-1:0]  key;
    logic                          press;

    logic [kpsdq_pkg::CODE_W-1:0] fifo_rd_data;
    logic [CNT_W-1:0]             fifo_count;
    kpsdq_pkg::t_fifo_status      fifo_status;

    assign ridx        = r_row[RIX_W-1:0];
    assign is_tick     = (r_action == kpsdq_pkg::ACT_TICK);
    assign sample      = r_sample & COL_MASK;
    assign cur_pending = r_pending[ridx];
    assign cur_stable  = r_stable[ridx];
    assign cur_cnt     = r_counter[ridx];
    assign limit       = {1'b0, r_debounce};
    assign changed     = (sample != cur_pending);
    assign counting    = !changed && (cur_cnt <= limit);
    assign settle      = counting && (cur_cnt == limit) && (cur_stable != sample);
    assign hit         = (cur_stable ^ sample) & sample;

    // lowest newly pressed column
    always_comb begin
        found   = 1'b0;
        hit_col = '0;
        for (int c = COLUMNS - 1; c >= 0; c--) begin
            if (hit[c]) begin
                found   = 1'b1;
                hit_col = 2'(c);
            end
        end
    end

    assign entry  = {r_row, hit_col};
    assign keymap = {r_keymap_high, r_keymap_low};
    assign key    = keymap[entry*kpsdq_pkg::CODE_W +: kpsdq_pkg::CODE_W];
    assign press  = is_tick && settle && found;

    assign n_row = (r_row == kpsdq_pkg::ROW_W'(ROWS - 1)) ? '0
                                                           : r_row + kpsdq_pkg::ROW_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_pending[r] <= '0;
                r_stable[r]  <= '0;
                r_counter[r] <= '0;
            end
        end else if (step && is_tick) begin
            r_row <= n_row;
            if (changed) begin
                r_pending[ridx] <= sample;
                r_counter[ridx] <= '0;
            end else if (counting) begin
                r_counter[ridx] <= cur_cnt + kpsdq_pkg::CTR_W'(1);
                if (settle) begin
                    r_stable[ridx] <= sample;
                end
            end
        end
    end

    kpsdq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_push      (press),
        .i_pop       (!is_tick),
        .i_push_data (key),
        .o_rd_data   (fifo_rd_data),
        .o_count     (fifo_count),
        .o_status    (fifo_status)
    );

    // result register
    logic r_key_valid, r_dropped;

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_key_valid <= !is_tick && !fifo_status.empty;
            r_dropped   <= press && fifo_status.full;
        end
    end

    assign o_result.valid       = r_res_valid;
    assign o_result.key_valid   = r_key_valid;
    assign o_result.key_code    = fifo_rd_data;
    assign o_result.row_select  = r_row;
    assign o_result.key_dropped = r_dropped;
    assign o_result.queue_count = fifo_count;

    // a transaction either pops or may drop, never both
    a_pop_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_key_valid && r_dropped))
        else $error("key_valid and key_dropped both set");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_key_valid) |-> (fifo_rd_data == '0))
        else $error("key_code nonzero without a popped key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && press && fifo_status.full) |=> (fifo_count == CNT_W'(QUEUE_DEPTH)))
        else $error("queue changed on a dropped key");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && is_tick) |=> (r_row == $past(n_row)))
        else $error("row did not advance on tick");

endmodule

// ----- tb/sv/kpsdq_key_checker.sv -----
// ----------------------------------------------------------------------------
// kpsdq_key_checker
// Watches the item, result and register channels of the keypad scanner,
// predicts each result from its own copy of the row, debounce and queue
// state, and compares every result transaction field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kpsdq_key_checker #(
    parameter int ROWS        = 4,
    parameter int COLUMNS     = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kpsdq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kpsdq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kpsdq_item_if                            i_item,
    kpsdq_result_if                          i_result,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_keys_popped,
    output int                               o_keys_dropped
);

    localparam logic [kpsdq_pkg::COL_W-1:0] COL_MASK =
        kpsdq_pkg::COL_W'((1 << COLUMNS) - 1);

    typedef struct packed {
        logic                         key_valid;
        logic [kpsdq_pkg::CODE_W-1:0] key_code;
        logic [kpsdq_pkg::ROW_W-1:0]  row_select;
        logic                         key_dropped;
        logic [3:0]                   queue_count;
    } t_key_result;

    logic [kpsdq_pkg::DEB_W-1:0]    debounce_lim;
    logic [kpsdq_pkg::KEYMAP_W-1:0] map_lo;
    logic [kpsdq_pkg::KEYMAP_W-1:0] map_hi;
    logic [kpsdq_pkg::COL_W-1:0]    pending_cols [ROWS];
    logic [kpsdq_pkg::COL_W-1:0]    stable_cols  [ROWS];
    logic [kpsdq_pkg::CTR_W-1:0]    stable_ctr   [ROWS];
    logic [kpsdq_pkg::CODE_W-1:0]   key_queue    [QUEUE_DEPTH];
    int unsigned                    scan_row;
    int unsigned                    queue_head;
    int unsigned                    queue_fill;
    t_key_result                    expected_keys [$];
    int                             fail_cnt;
    int                             popped_cnt;
    int                             dropped_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] key check: %s", $time, msg);
        fail_cnt++;
    endtask

    // one step of the scanner: a read pops the oldest key, a tick debounces one row
    function automatic t_key_result predict_key_step(
        input logic                        act,
        input logic [kpsdq_pkg::COL_W-1:0] cols
    );
        t_key_result                        res;
        logic [kpsdq_pkg::COL_W-1:0]        smp;
        logic [kpsdq_pkg::COL_W-1:0]        hit;
        logic [2*kpsdq_pkg::KEYMAP_W-1:0]   key_table;
        logic [kpsdq_pkg::CODE_W-1:0]       code;
        int                                 col;
        int                                 entry_bit;
        res = '0;
        if (act == kpsdq_pkg::ACT_READ) begin
            if (queue_fill > 0) begin
                res.key_valid = 1'b1;
                res.key_code  = key_queue[queue_head];
                queue_head    = (queue_head + 1) % QUEUE_DEPTH;
                queue_fill--;
                popped_cnt++;
            end
        end else begin
            smp = cols & COL_MASK;
            if (smp != pending_cols[scan_row]) begin
                pending_cols[scan_row] = smp;
                stable_ctr[scan_row]   = '0;
            end else if (stable_ctr[scan_row] <= {1'b0, debounce_lim}) begin
                if (stable_ctr[scan_row] == {1'b0, debounce_lim}
                        && stable_cols[scan_row] != smp) begin
                    // lowest column that is newly pressed
                    hit = (stable_cols[scan_row] ^ smp) & smp;
                    col = -1;
                    for (int k = COLUMNS - 1; k >= 0; k--) begin
                        if (hit[k]) col = k;
                    end
                    if (col >= 0) begin
                        key_table = {map_hi, map_lo};
                        entry_bit = kpsdq_pkg::CODE_W * (scan_row * 4 + col);
                        code = key_table[entry_bit +: kpsdq_pkg::CODE_W];
                        if (queue_fill < QUEUE_DEPTH) begin
                            key_queue[(queue_head + queue_fill) % QUEUE_DEPTH] = code;
                            queue_fill++;
                        end else begin
                            res.key_dropped = 1'b1;
                            dropped_cnt++;
                        end
                    end
                    stable_cols[scan_row] = smp;
                end
                stable_ctr[scan_row] = stable_ctr[scan_row] + 1'b1;
            end
            scan_row = (scan_row + 1 >= ROWS) ? 0 : scan_row + 1;
        end
        res.row_select  = kpsdq_pkg::ROW_W'(scan_row);
        res.queue_count = 4'(queue_fill);
        return res;
    endfunction

    initial begin
        fail_cnt    = 0;
        popped_cnt  = 0;
        dropped_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_key_result want;
        if (!i_rst_n) begin
            debounce_lim = kpsdq_pkg::DEBOUNCE_RST;
            map_lo       = kpsdq_pkg::KEYMAP_LOW_RST;
            map_hi       = kpsdq_pkg::KEYMAP_HIGH_RST;
            for (int r = 0; r < ROWS; r++) begin
                pending_cols[r] = '0;
                stable_cols[r]  = '0;
                stable_ctr[r]   = '0;
            end
            scan_row   = 0;
            queue_head = 0;
            queue_fill = 0;
            expected_keys.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kpsdq_pkg::CFG_DEBOUNCE:
                        debounce_lim = i_cfg_data[kpsdq_pkg::DEB_W-1:0];
                    kpsdq_pkg::CFG_KEYMAP_LOW:
                        map_lo = i_cfg_data[kpsdq_pkg::KEYMAP_W-1:0];
                    kpsdq_pkg::CFG_KEYMAP_HIGH:
                        map_hi = i_cfg_data[kpsdq_pkg::KEYMAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1) begin
                if (expected_keys.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_keys.pop_front();
                    if (i_result.key_valid !== want.key_valid)
                        report_mismatch($sformatf("key_valid %b, expected %b",
                                                  i_result.key_valid, want.key_valid));
                    if (i_result.key_code !== want.key_code)
                        report_mismatch($sformatf("key_code %h, expected %h",
                                                  i_result.key_code, want.key_code));
                    if (i_result.row_select !== want.row_select)
                        report_mismatch($sformatf("row_select %0d, expected %0d",
                                                  i_result.row_select, want.row_select));
                    if (i_result.key_dropped !== want.key_dropped)
                        report_mismatch($sformatf("key_dropped %b, expected %b",
                                                  i_result.key_dropped, want.key_dropped));
                    if (i_result.queue_count !== 4'(want.queue_count))
                        report_mismatch($sformatf("queue_count %0d, expected %0d",
                                                  i_result.queue_count, want.queue_count));
                end
            end
            if (i_item.valid === 1'b1 && i_item.ready === 1'b1) begin
                expected_keys.push_back(predict_key_step(i_item.action, i_item.column_sample));
            end
        end
        o_pending      <= expected_keys.size();
        o_fail_count   <= fail_cnt;
        o_keys_popped  <= popped_cnt;
        o_keys_dropped <= dropped_cnt;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keypad scanner: directed presses that fill
// and overflow the key queue, then keypad-like random scans with bounce
// under several debounce and key map settings, with random stalls on both
// sides; checking is done by kpsdq_key_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int QUEUE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 6;
    localparam int GAP_PCT     = 12;
    localparam int STALL_PCT   = 20;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_cfg_we   = 1'b0;
    logic [kpsdq_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [kpsdq_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    kpsdq_item_if                 item_if ();
    kpsdq_result_if #(.CNT_W(4))  result_if ();

    int  fail_count;
    int  pending;
    int  keys_popped;
    int  keys_dropped;
    int  cycle_count    = 0;
    int  items_sent     = 0;
    int  settings_used  = 0;
    int  scan_pos       = 0;
    bit  hold_request   = 1'b0;
    bit  no_idle        = 1'b0;

    // keypad picture per row, and remaining bouncy samples after a change
    logic [kpsdq_pkg::COL_W-1:0] held_cols   [4];
    int                          bounce_left [4];

    keypad_scan_debounce_queue #(
        .ROWS        (4),
        .COLUMNS     (4),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if.sink),
        .o_result   (result_if.source)
    );

    kpsdq_key_checker #(
        .ROWS        (4),
        .COLUMNS     (4),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) key_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_item         (item_if),
        .i_result       (result_if),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_keys_popped  (keys_popped),
        .o_keys_dropped (keys_dropped)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic act, input logic [kpsdq_pkg::COL_W-1:0] cols);
        if (!no_idle && $urandom_range(0, 99) < GAP_PCT) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.action        <= act;
        item_if.column_sample <= cols;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        items_sent++;
        if (act == kpsdq_pkg::ACT_TICK) scan_pos = (scan_pos + 1) % 4;
    endtask

    // drain everything in flight, then let the pipeline settle
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [kpsdq_pkg::DEB_W-1:0] deb,
                               input logic [kpsdq_pkg::KEYMAP_W-1:0] map_lo,
                               input logic [kpsdq_pkg::KEYMAP_W-1:0] map_hi);
        logic [kpsdq_pkg::CFG_DATA_W-1:0] junk;
        wait_idle();
        // upper bits of the debounce write carry noise, only the low byte counts
        junk = {$urandom, $urandom};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= kpsdq_pkg::CFG_DEBOUNCE;
        i_cfg_data <= {junk[kpsdq_pkg::CFG_DATA_W-1:kpsdq_pkg::DEB_W], deb};
        @(posedge i_clk);
        i_cfg_idx  <= kpsdq_pkg::CFG_KEYMAP_LOW;
        i_cfg_data <= map_lo;
        @(posedge i_clk);
        i_cfg_idx  <= kpsdq_pkg::CFG_KEYMAP_HIGH;
        i_cfg_data <= map_hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic random_items(input int n_items, input int read_pct, input int change_pct);
        logic [kpsdq_pkg::COL_W-1:0] cols;
        logic [kpsdq_pkg::COL_W-1:0] one_col;
        int                          r;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                push_item(kpsdq_pkg::ACT_READ, kpsdq_pkg::COL_W'($urandom));
                continue;
            end
            r = scan_pos;
            if ($urandom_range(0, 99) < change_pct) begin
                one_col = kpsdq_pkg::COL_W'(1) << $urandom_range(0, kpsdq_pkg::COL_W - 1);
                case ($urandom_range(0, 3))
                    0:       held_cols[r] = '0;
                    1:       held_cols[r] = one_col;
                    2:       held_cols[r] = held_cols[r] | one_col;
                    default: held_cols[r] = kpsdq_pkg::COL_W'($urandom);
                endcase
                bounce_left[r] = $urandom_range(0, 3);
            end
            if (bounce_left[r] > 0) begin
                bounce_left[r]--;
                cols = kpsdq_pkg::COL_W'($urandom);
            end else if ($urandom_range(0, 99) < 3) begin
                cols = kpsdq_pkg::COL_W'($urandom);
            end else begin
                cols = held_cols[r];
            end
            push_item(kpsdq_pkg::ACT_TICK, cols);
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin : result_sink
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                result_if.ready <= 1'b0;
                hold_request = 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(0, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        // nibble r of each pattern is the sample for row r
        logic [15:0] press_pat [3];
        press_pat = '{16'h8421, 16'h9C63, 16'hBDE7};
        item_if.valid         = 1'b0;
        item_if.action        = kpsdq_pkg::ACT_TICK;
        item_if.column_sample = '0;
        for (int r = 0; r < 4; r++) begin
            held_cols[r]   = '0;
            bounce_left[r] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // read on an empty queue straight out of reset
        push_item(kpsdq_pkg::ACT_READ, '0);

        // debounce 0: single presses, then second and third columns per row;
        // the third round finds the queue full and drops every key
        load_config(8'd0, kpsdq_pkg::KEYMAP_LOW_RST, kpsdq_pkg::KEYMAP_HIGH_RST);
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 8; k++) begin
                push_item(kpsdq_pkg::ACT_TICK, press_pat[p][4 * scan_pos +: 4]);
            end
        end
        repeat (4) push_item(kpsdq_pkg::ACT_READ, '0);

        load_config(8'd0, {$urandom, $urandom}, {$urandom, $urandom});
        random_items(250, 30, 8);

        // rare reads fill the queue; receiver holds off while items keep coming
        load_config(8'd1, '0, '1);
        hold_request = 1'b1;
        random_items(200, 2, 15);

        load_config(8'd3, {$urandom, $urandom}, {$urandom, $urandom});
        random_items(250, 25, 6);

        load_config(8'd255, {$urandom, $urandom}, {$urandom, $urandom});
        random_items(80, 20, 6);

        load_config(8'd2, {$urandom, $urandom}, {$urandom, $urandom});
        random_items(125, 40, 8);
        wait_idle();
        random_items(125, 40, 8);

        no_idle = 1'b1;
        load_config(kpsdq_pkg::DEBOUNCE_RST, kpsdq_pkg::KEYMAP_LOW_RST,
                    kpsdq_pkg::KEYMAP_HIGH_RST);
        random_items(370, 25, 6);

        wait_idle();
        $display("%0d transactions under %0d register settings, debounce 0 through 255",
                 items_sent, settings_used);
        $display("%0d keys read back, %0d presses dropped on a full queue",
                 keys_popped, keys_dropped);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- keypad_scan_debounce_queue.f -----
rtl/core/kpsdq_pkg.sv
rtl/core/kpsdq_item_if.sv
rtl/core/kpsdq_result_if.sv
rtl/core/kpsdq_fifo.sv
rtl/core/keypad_scan_debounce_queue.sv
tb/sv/kpsdq_key_checker.sv
tb/sv/tb_top.sv
